// ===== sv/swmm_pkg.sv =====
package swmm_pkg;

    // Width of the window length register
    localparam int CFG_W = 9;

    // Width of the lower and upper bound words
    localparam int OUT_W = 32;

    // Window length after reset
    localparam logic [CFG_W-1:0] LEN_RESET = CFG_W'(20);

endpackage

// ===== sv/swmm_cell.sv =====
module swmm_cell #(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_shift,
    input  logic [W-1:0] i_data,
    output logic [W-1:0] o_data,
    input  logic         i_include,
    input  logic         i_tok_vld,
    input  logic [W-1:0] i_tok_min,
    input  logic [W-1:0] i_tok_max,
    output logic         o_tok_vld,
    output logic [W-1:0] o_tok_min,
    output logic [W-1:0] o_tok_max
);

    logic [W-1:0] r_data;
    logic [W-1:0] n_data;
    logic         r_tok_vld;
    logic [W-1:0] r_tok_min;
    logic [W-1:0] n_tok_min;
    logic [W-1:0] r_tok_max;
    logic [W-1:0] n_tok_max;

    // Merge against the sample this cell holds after any shift
    always_comb begin
        n_data    = i_shift ? i_data : r_data;
        n_tok_min = i_tok_min;
        n_tok_max = i_tok_max;
        if (i_include) begin
            if ($signed(n_data) < $signed(i_tok_min)) begin
                n_tok_min = n_data;
            end
            if ($signed(n_data) > $signed(i_tok_max)) begin
                n_tok_max = n_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_vld <= 1'b0;
        end else begin
            r_tok_vld <= i_tok_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (i_tok_vld) begin
            r_tok_min <= n_tok_min;
            r_tok_max <= n_tok_max;
        end
    end

    assign o_data    = r_data;
    assign o_tok_vld = r_tok_vld;
    assign o_tok_min = r_tok_min;
    assign o_tok_max = r_tok_max;

endmodule

// ===== sv/swmm_chain.sv =====
module swmm_chain #(
    parameter int MAX_WINDOW  = 256,
    parameter int SAMPLE_BITS = 32,
    parameter int CNT_W       = 9
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_shift,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [CNT_W-1:0]       i_len,
    output logic                   o_tail_vld,
    output logic [SAMPLE_BITS-1:0] o_tail_min,
    output logic [SAMPLE_BITS-1:0] o_tail_max
);

    logic [SAMPLE_BITS-1:0] data_a    [MAX_WINDOW];
    logic                   tok_vld_a [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] tok_min_a [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] tok_max_a [MAX_WINDOW];

    for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
        localparam logic [CNT_W-1:0] IDX = CNT_W'(k);
        logic                   incl;
        logic                   in_vld;
        logic [SAMPLE_BITS-1:0] in_data;
        logic [SAMPLE_BITS-1:0] in_min;
        logic [SAMPLE_BITS-1:0] in_max;

        // Only the newest i_len cells count toward the bounds
        assign incl = (IDX < i_len);

        if (k == 0) begin : g_head
            // Inject the new word as the seed of the scan token
            assign in_data = i_sample;
            assign in_vld  = i_shift;
            assign in_min  = i_sample;
            assign in_max  = i_sample;
        end else begin : g_body
            assign in_data = data_a[k-1];
            assign in_vld  = tok_vld_a[k-1];
            assign in_min  = tok_min_a[k-1];
            assign in_max  = tok_max_a[k-1];
        end

        swmm_cell #(
            .W (SAMPLE_BITS)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_shift   (i_shift),
            .i_data    (in_data),
            .o_data    (data_a[k]),
            .i_include (incl),
            .i_tok_vld (in_vld),
            .i_tok_min (in_min),
            .i_tok_max (in_max),
            .o_tok_vld (tok_vld_a[k]),
            .o_tok_min (tok_min_a[k]),
            .o_tok_max (tok_max_a[k])
        );
    end

    assign o_tail_vld = tok_vld_a[MAX_WINDOW-1];
    assign o_tail_min = tok_min_a[MAX_WINDOW-1];
    assign o_tail_max = tok_max_a[MAX_WINDOW-1];

endmodule

// ===== sv/sliding_window_min_max_top.sv =====
// Sliding window minimum and maximum (Donchian channel) of signed Q16.16 words.
//
// Input channel: i_valid / i_sample, o_stall. A word is taken at a rising edge
// with i_valid high and o_stall low. Output channel: o_valid / o_lower_bound /
// o_upper_bound, i_stall. A result word leaves at an edge with o_valid high
// and i_stall low. Config channel: i_cfg_valid / i_cfg_window_length with
// o_cfg_ready (always high); write it only while the block is idle. A write
// restarts the channel, and the window fills again before results appear.
//
// Samples sit in a row of MAX_WINDOW cells. An accepted word shifts the row by
// one cell, then a scan token walks the row one cell per cycle, folding in the
// cells that lie inside the window. The next word is taken only once the token
// has left the row and its result, if any, has reached the output register.
// The first eff_len - 1 words after a restart give no result, where eff_len is
// the window length with zero taken as one and clamped to MAX_WINDOW.
//
// Reset (synchronous, active low) sets the window length to 20, empties the
// window and drops any result in flight. If the receiver stalls, the result
// holds in the output register; one more result parks behind it and the input
// stays stalled until that one moves up.
module sliding_window_min_max_top #(
    parameter int MAX_WINDOW  = 256,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [SAMPLE_BITS-1:0]      i_sample,
    output logic                        o_stall,
    output logic                        o_valid,
    output logic [swmm_pkg::OUT_W-1:0]  o_lower_bound,
    output logic [swmm_pkg::OUT_W-1:0]  o_upper_bound,
    input  logic                        i_stall,
    input  logic                        i_cfg_valid,
    input  logic [swmm_pkg::CFG_W-1:0]  i_cfg_window_length,
    output logic                        o_cfg_ready
);

    import swmm_pkg::*;

    localparam int MW_W  = $clog2(MAX_WINDOW + 1);
    localparam int CNT_W = (MW_W > CFG_W) ? MW_W : CFG_W;

    logic [CFG_W-1:0]       r_window_length;
    logic [CNT_W-1:0]       len_ext;
    logic [CNT_W-1:0]       eff_len;
    logic [CNT_W-1:0]       r_fill;
    logic [CNT_W-1:0]       n_fill;
    logic                   r_busy;
    logic                   r_emit;
    logic                   r_out_vld;
    logic [OUT_W-1:0]       r_out_min;
    logic [OUT_W-1:0]       r_out_max;
    logic                   r_pend_vld;
    logic [OUT_W-1:0]       r_pend_min;
    logic [OUT_W-1:0]       r_pend_max;
    logic                   accept;
    logic                   cfg_wr;
    logic                   out_free;
    logic                   tail_vld;
    logic                   tail_res;
    logic [SAMPLE_BITS-1:0] tail_min;
    logic [SAMPLE_BITS-1:0] tail_max;
    logic [OUT_W-1:0]       tail_min_o;
    logic [OUT_W-1:0]       tail_max_o;

    assign accept      = i_valid && !r_busy;
    assign cfg_wr      = i_cfg_valid;
    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_busy;

    // Zero acts as one; clamp to the depth of the cell row
    always_comb begin
        len_ext = CNT_W'(r_window_length);
        if (len_ext == '0) begin
            eff_len = CNT_W'(1);
        end else if (len_ext > CNT_W'(MAX_WINDOW)) begin
            eff_len = CNT_W'(MAX_WINDOW);
        end else begin
            eff_len = len_ext;
        end
    end

    // Saturate the fill count at the window length
    assign n_fill = (r_fill < eff_len) ? (r_fill + CNT_W'(1)) : r_fill;

    swmm_chain #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .CNT_W       (CNT_W)
    ) u_chain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_shift    (accept),
        .i_sample   (i_sample),
        .i_len      (eff_len),
        .o_tail_vld (tail_vld),
        .o_tail_min (tail_min),
        .o_tail_max (tail_max)
    );

    // Fit the sample width to the result word
    if (SAMPLE_BITS >= OUT_W) begin : g_trunc
        assign tail_min_o = tail_min[OUT_W-1:0];
        assign tail_max_o = tail_max[OUT_W-1:0];
    end else begin : g_ext
        assign tail_min_o = {{(OUT_W - SAMPLE_BITS){1'b0}}, tail_min};
        assign tail_max_o = {{(OUT_W - SAMPLE_BITS){1'b0}}, tail_max};
    end

    assign tail_res = tail_vld && r_emit;
    assign out_free = !r_out_vld || !i_stall;

    // Control: window length, fill count, busy, output and parking slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= LEN_RESET;
            r_fill          <= '0;
            r_busy          <= 1'b0;
            r_emit          <= 1'b0;
            r_out_vld       <= 1'b0;
            r_pend_vld      <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_window_length <= i_cfg_window_length;
                r_fill          <= '0;
            end else if (accept) begin
                r_fill <= n_fill;
                r_emit <= (n_fill >= eff_len);
            end

            if (accept) begin
                r_busy <= 1'b1;
            end else if (tail_vld && (!tail_res || out_free)) begin
                r_busy <= 1'b0;
            end else if (r_pend_vld && out_free) begin
                r_busy <= 1'b0;
            end

            if (out_free) begin
                if (r_pend_vld) begin
                    r_out_vld  <= 1'b1;
                    r_pend_vld <= 1'b0;
                end else if (tail_res) begin
                    r_out_vld <= 1'b1;
                end else begin
                    r_out_vld <= 1'b0;
                end
            end else if (tail_res) begin
                r_pend_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_pend_vld) begin
                r_out_min <= r_pend_min;
                r_out_max <= r_pend_max;
            end else if (tail_res) begin
                r_out_min <= tail_min_o;
                r_out_max <= tail_max_o;
            end
        end else if (tail_res) begin
            r_pend_min <= tail_min_o;
            r_pend_max <= tail_max_o;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_lower_bound = r_out_min;
    assign o_upper_bound = r_out_max;

endmodule

// ===== sv/swmm_checker.sv =====
module swmm_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_stall,
    input logic                       o_valid,
    input logic [swmm_pkg::OUT_W-1:0] o_lower_bound,
    input logic [swmm_pkg::OUT_W-1:0] o_upper_bound,
    input logic                       i_stall
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> ($stable(o_lower_bound) && $stable(o_upper_bound)))
        else $error("stalled result word changed");

    // One word at a time: the input closes right after a word is taken
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input open right after a word was taken");

    // Reset drops any result in flight
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("result or busy left over after reset");

endmodule

bind sliding_window_min_max_top swmm_checker u_swmm_checker (.*);
